[hdl/pba_pkg.sv]
package pba_pkg;

    localparam int unsigned PG_SHIFT = 12;
    localparam logic [31:0] NO_ADDR  = 32'hFFFF_FFFF;
    localparam logic [16:0] CNT_MAX  = 17'h1_FFFF;

    localparam logic [2:0] MODE_AVAIL   = 3'd0;
    localparam logic [2:0] MODE_RESERVE = 3'd1;
    localparam logic [2:0] MODE_ALLOC   = 3'd2;
    localparam logic [2:0] MODE_FREE    = 3'd3;
    localparam logic [2:0] MODE_SEAL    = 3'd4;

    // map entry: bit 0 used, bit 1 reserved
    localparam logic [1:0] ENT_FREE  = 2'b00;
    localparam logic [1:0] ENT_USED  = 2'b01;
    localparam logic [1:0] ENT_RESVD = 2'b11;

    typedef logic [16:0] t_cnt;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_PAGES,
        S_AVAIL,
        S_RESV,
        S_ASCAN,
        S_AWR,
        S_FCHK,
        S_FREL,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [2:0]  mode;
        logic [63:0] range_base;
        logic [63:0] range_length;
        logic [16:0] page_total;
        logic [31:0] release_address;
    } t_req;

    typedef struct packed {
        logic        ok;
        logic [31:0] alloc_address;
        logic [16:0] free_pages;
        logic [16:0] usable_pages;
    } t_rsp;

    function automatic t_cnt cnt_inc(input t_cnt c);
        return (c < CNT_MAX) ? t_cnt'(c + 1'b1) : c;
    endfunction

    function automatic t_cnt cnt_dec(input t_cnt c);
        return (c != '0) ? t_cnt'(c - 1'b1) : c;
    endfunction

endpackage

[hdl/pba_if.sv]
interface pba_req_if;
    logic            valid;
    logic            ready;
    pba_pkg::t_req   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface pba_rsp_if;
    logic            valid;
    logic            ready;
    pba_pkg::t_rsp   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hdl/page_bitmap_allocator_unit.sv]
// From acceptance to result valid: S_SETUP, then S_FIN for seal and rejected requests;
//   range requests pass S_PAGES and scan the range; alloc scans from FIRST_PAGE, then
//   writes the run back; free checks its pages for reservations, then releases them.
// Throughput: one transaction at a time, as a request is taken only in S_IDLE.
// Reset: synchronous; a clearing pass marks every page of the map used
//   before the first request is taken.
module page_bitmap_allocator_unit #(
    parameter int unsigned PAGE_COUNT = 65536,
    parameter int unsigned FIRST_PAGE = 256
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    pba_req_if.sink             i_req,
    pba_rsp_if.source           o_rsp
);

    localparam int unsigned AW = $clog2(PAGE_COUNT);
    localparam int unsigned PW = AW + 1;
    localparam int unsigned SCAN_LO = (FIRST_PAGE < PAGE_COUNT) ? FIRST_PAGE : PAGE_COUNT;
    localparam logic [21:0] PC22 = 22'(PAGE_COUNT);

    pba_pkg::t_state r_state, n_state;
    logic [2:0]      r_mode, n_mode;
    logic [63:0]     r_base, n_base;
    logic [63:0]     r_len, n_len;
    logic [16:0]     r_cnt, n_cnt;
    logic [31:0]     r_raddr, n_raddr;
    logic [32:0]     r_end33, n_end33;
    logic            r_skip, n_skip;
    logic [PW-1:0]   r_p, n_p;
    logic [PW-1:0]   r_end, n_end;
    logic [PW-1:0]   r_q, n_q;
    logic            r_qv, n_qv;
    logic [16:0]     r_run, n_run;
    logic [PW-1:0]   r_astart, n_astart;
    pba_pkg::t_cnt   r_usable, n_usable;
    pba_pkg::t_cnt   r_free, n_free;
    logic            r_ready, n_ready;
    logic            r_ok, n_ok;
    logic [31:0]     r_addr, n_addr;
    logic            r_ovalid, n_ovalid;
    pba_pkg::t_rsp   r_rsp, n_rsp;

    logic [1:0]      r_mem [PAGE_COUNT];
    logic [1:0]      r_rdata;
    logic            mem_we, mem_re;
    logic [AW-1:0]   mem_wa, mem_ra;
    logic [1:0]      mem_wd;

    logic [64:0]     sum65;
    logic            over;
    logic [32:0]     fsum;
    logic [21:0]     fsp, fend, sp22, ep22;
    logic            issue, scan_done, pg_used, pg_resv;
    logic [16:0]     run_nx;

    assign i_req.ready = (r_state == pba_pkg::S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    always_comb begin
        sum65 = {1'b0, r_base} + {1'b0, r_len};
        over  = (sum65[64:32] > 33'd1) || ((sum65[64:32] == 33'd1) && (sum65[31:0] != '0));
        fsum  = {1'b0, r_raddr} + {4'b0, r_cnt, 12'b0};
        fsp   = {2'b0, r_raddr[31:12]};
        fend  = fsp + {5'b0, r_cnt};
        if (r_mode == pba_pkg::MODE_AVAIL) begin
            sp22 = {1'b0, 21'(({1'b0, r_base[31:0]} + 33'd4095) >> pba_pkg::PG_SHIFT)};
            ep22 = {1'b0, r_end33[32:12]};
        end else begin
            sp22 = {2'b0, r_base[31:12]};
            ep22 = {1'b0, 21'(({1'b0, r_end33} + 34'd4095) >> pba_pkg::PG_SHIFT)};
        end
        if (ep22 > PC22) begin
            ep22 = PC22;
        end
        pg_used   = r_rdata[0];
        pg_resv   = r_rdata[1];
        run_nx    = (!pg_used && !pg_resv) ? 17'(r_run + 1'b1) : '0;
        issue     = (r_p < r_end);
        scan_done = !issue && !r_qv;
    end

    always_comb begin
        n_state = r_state;   n_mode = r_mode;     n_base = r_base;   n_len = r_len;
        n_cnt = r_cnt;       n_raddr = r_raddr;   n_end33 = r_end33; n_skip = r_skip;
        n_p = r_p;           n_end = r_end;       n_q = r_p;         n_qv = 1'b0;
        n_run = r_run;       n_astart = r_astart; n_usable = r_usable;
        n_free = r_free;     n_ready = r_ready;   n_ok = r_ok;       n_addr = r_addr;
        n_ovalid = r_ovalid; n_rsp = r_rsp;
        mem_we = 1'b0;  mem_wa = r_q[AW-1:0];  mem_wd = r_rdata;
        mem_re = 1'b0;  mem_ra = r_p[AW-1:0];

        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end

        if ((r_state == pba_pkg::S_AVAIL) || (r_state == pba_pkg::S_RESV) ||
            (r_state == pba_pkg::S_ASCAN) || (r_state == pba_pkg::S_FCHK) ||
            (r_state == pba_pkg::S_FREL)) begin
            if (issue) begin
                mem_re = 1'b1;
                n_p    = PW'(r_p + 1'b1);
                n_qv   = 1'b1;
            end
        end

        unique case (r_state)
            pba_pkg::S_CLR: begin
                mem_we = 1'b1;
                mem_wa = r_p[AW-1:0];
                mem_wd = pba_pkg::ENT_USED;
                n_p    = PW'(r_p + 1'b1);
                if (r_p == PW'(PAGE_COUNT - 1)) begin
                    n_state = pba_pkg::S_IDLE;
                end
            end
            pba_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_mode  = i_req.data.mode;
                    n_base  = i_req.data.range_base;
                    n_len   = i_req.data.range_length;
                    n_cnt   = i_req.data.page_total;
                    n_raddr = i_req.data.release_address;
                    n_ok    = 1'b0;
                    n_addr  = pba_pkg::NO_ADDR;
                    n_state = pba_pkg::S_SETUP;
                end
            end
            pba_pkg::S_SETUP: begin
                n_skip  = (r_len == '0) || (r_base[63:32] != '0);
                n_end33 = over ? 33'h1_0000_0000 : sum65[32:0];
                n_state = pba_pkg::S_FIN;
                unique case (r_mode)
                    pba_pkg::MODE_AVAIL, pba_pkg::MODE_RESERVE: begin
                        n_state = pba_pkg::S_PAGES;
                    end
                    pba_pkg::MODE_ALLOC: begin
                        if (r_ready && (r_cnt != '0) && ({5'b0, r_cnt} <= PC22)) begin
                            n_p     = PW'(SCAN_LO);
                            n_end   = PW'(PAGE_COUNT);
                            n_run   = '0;
                            n_state = pba_pkg::S_ASCAN;
                        end
                    end
                    pba_pkg::MODE_FREE: begin
                        if (r_ready && (r_cnt != '0) && (r_raddr[11:0] == '0) &&
                            (fsum <= 33'h1_0000_0000) && (fsp >= 22'(FIRST_PAGE)) &&
                            (fend <= PC22)) begin
                            n_p      = PW'(fsp);
                            n_astart = PW'(fsp);
                            n_end    = PW'(fend);
                            n_state  = pba_pkg::S_FCHK;
                        end
                    end
                    pba_pkg::MODE_SEAL: begin
                        if (r_free != '0) begin
                            n_ready = 1'b1;
                        end
                        n_ok = (r_free != '0) || r_ready;
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            pba_pkg::S_PAGES: begin
                n_ok    = 1'b1;
                n_state = pba_pkg::S_FIN;
                if (!r_skip && (sp22 < PC22)) begin
                    if (r_mode == pba_pkg::MODE_RESERVE) begin
                        n_p     = PW'(sp22);
                        n_end   = PW'(ep22);
                        n_state = pba_pkg::S_RESV;
                    end else if (sp22 < {1'b0, r_end33[32:12]}) begin
                        n_p     = PW'(sp22);
                        n_end   = PW'(ep22);
                        n_state = pba_pkg::S_AVAIL;
                    end
                end
            end
            pba_pkg::S_AVAIL: begin
                if (r_qv && pg_used && !pg_resv) begin
                    mem_we   = 1'b1;
                    mem_wd   = pba_pkg::ENT_FREE;
                    n_usable = pba_pkg::cnt_inc(r_usable);
                    n_free   = pba_pkg::cnt_inc(r_free);
                end
                if (scan_done) begin
                    n_state = pba_pkg::S_FIN;
                end
            end
            pba_pkg::S_RESV: begin
                if (r_qv && !pg_resv) begin
                    mem_we = 1'b1;
                    mem_wd = pba_pkg::ENT_RESVD;
                    if (!pg_used) begin
                        n_usable = pba_pkg::cnt_dec(r_usable);
                        n_free   = pba_pkg::cnt_dec(r_free);
                    end
                end
                if (scan_done) begin
                    n_state = pba_pkg::S_FIN;
                end
            end
            pba_pkg::S_ASCAN: begin
                if (r_qv) begin
                    n_run = run_nx;
                    if (run_nx == r_cnt) begin
                        n_astart = PW'(r_q + 1'b1 - PW'(r_cnt));
                        n_p      = PW'(r_q + 1'b1 - PW'(r_cnt));
                        n_end    = PW'(r_q + 1'b1);
                        n_qv     = 1'b0;
                        n_state  = pba_pkg::S_AWR;
                    end
                end
                if (scan_done) begin
                    n_state = pba_pkg::S_FIN;
                end
            end
            pba_pkg::S_AWR: begin
                if (issue) begin
                    mem_we = 1'b1;
                    mem_wa = r_p[AW-1:0];
                    mem_wd = pba_pkg::ENT_USED;
                    n_free = pba_pkg::cnt_dec(r_free);
                    n_p    = PW'(r_p + 1'b1);
                end else begin
                    n_ok    = 1'b1;
                    n_addr  = 32'({r_astart, 12'b0});
                    n_state = pba_pkg::S_FIN;
                end
            end
            pba_pkg::S_FCHK: begin
                if (r_qv && pg_resv) begin
                    n_qv    = 1'b0;
                    n_state = pba_pkg::S_FIN;
                end else if (scan_done) begin
                    n_p     = r_astart;
                    n_state = pba_pkg::S_FREL;
                end
            end
            pba_pkg::S_FREL: begin
                if (r_qv && pg_used) begin
                    mem_we = 1'b1;
                    mem_wd = pba_pkg::ENT_FREE;
                    n_free = pba_pkg::cnt_inc(r_free);
                end
                if (scan_done) begin
                    n_ok    = 1'b1;
                    n_state = pba_pkg::S_FIN;
                end
            end
            pba_pkg::S_FIN: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid                = 1'b1;
                    n_rsp.ok                = r_ok;
                    n_rsp.alloc_address     = r_addr;
                    n_rsp.free_pages        = r_free;
                    n_rsp.usable_pages      = r_usable;
                    n_state                 = pba_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = pba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= pba_pkg::S_CLR;
            r_p      <= '0;
            r_end    <= '0;
            r_qv     <= 1'b0;
            r_usable <= '0;
            r_free   <= '0;
            r_ready  <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p      <= n_p;
            r_end    <= n_end;
            r_qv     <= n_qv;
            r_usable <= n_usable;
            r_free   <= n_free;
            r_ready  <= n_ready;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_base   <= n_base;
        r_len    <= n_len;
        r_cnt    <= n_cnt;
        r_raddr  <= n_raddr;
        r_end33  <= n_end33;
        r_skip   <= n_skip;
        r_q      <= n_q;
        r_run    <= n_run;
        r_astart <= n_astart;
        r_ok     <= n_ok;
        r_addr   <= n_addr;
        r_rsp    <= n_rsp;
    end

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pba_pkg::S_IDLE) |-> !mem_we)
        else $error("map written while idle");

    a_qv_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qv |-> $past(mem_re))
        else $error("read data flagged without a read");

    a_ready_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |=> r_ready)
        else $error("ready flag cleared");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int PGS = 65536;
    localparam int FIRST_PG = 256;
    localparam logic [64:0] LIMIT_4G = 65'h1_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    pba_req_if req_if();
    pba_rsp_if rsp_if();

    page_bitmap_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    bit            used_pg [PGS];
    bit            resv_pg [PGS];
    pba_pkg::t_cnt usable_cnt;
    pba_pkg::t_cnt free_cnt;
    bit            alloc_ready;

    pba_pkg::t_req pending_reqs[$];
    pba_pkg::t_rsp expected_rsps[$];
    int   n_errors = 0;
    int   n_checked = 0;
    int   n_alloc_ok = 0;
    int   n_free_ok = 0;
    bit   req_fire = 1'b0;
    int   req_gap = 0;
    int   rsp_gap = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic pba_pkg::t_rsp predict_page_map(pba_pkg::t_req r);
        pba_pkg::t_rsp   o;
        logic [64:0]     e;
        longint unsigned sp, ep;
        int              p, run, st;
        bit              bad;
        o.ok = 1'b0;
        o.alloc_address = pba_pkg::NO_ADDR;
        case (r.mode)
            pba_pkg::MODE_AVAIL, pba_pkg::MODE_RESERVE: begin
                o.ok = 1'b1;
                if (r.range_length != 0 && {1'b0, r.range_base} < LIMIT_4G) begin
                    e = {1'b0, r.range_base} + {1'b0, r.range_length};
                    if (e > LIMIT_4G) e = LIMIT_4G;
                    if (r.mode == pba_pkg::MODE_AVAIL) begin
                        sp = (r.range_base + 64'd4095) >> 12;
                        ep = longint'(e >> 12);
                        if (sp < ep && sp < PGS) begin
                            if (ep > PGS) ep = PGS;
                            for (p = int'(sp); p < int'(ep); p++) begin
                                if (used_pg[p] && !resv_pg[p]) begin
                                    used_pg[p] = 1'b0;
                                    if (usable_cnt < 17'h1FFFF) usable_cnt++;
                                    if (free_cnt < 17'h1FFFF) free_cnt++;
                                end
                            end
                        end
                    end else begin
                        sp = r.range_base >> 12;
                        ep = longint'((e + 65'd4095) >> 12);
                        if (sp < PGS) begin
                            if (ep > PGS) ep = PGS;
                            for (p = int'(sp); p < int'(ep); p++) begin
                                if (!resv_pg[p]) begin
                                    if (!used_pg[p]) begin
                                        if (usable_cnt != 0) usable_cnt--;
                                        if (free_cnt != 0) free_cnt--;
                                    end
                                    resv_pg[p] = 1'b1;
                                    used_pg[p] = 1'b1;
                                end
                            end
                        end
                    end
                end
            end
            pba_pkg::MODE_ALLOC: begin
                if (alloc_ready && r.page_total != 0 && r.page_total <= PGS) begin
                    run = 0;
                    for (p = FIRST_PG; p < PGS; p++) begin
                        if (!used_pg[p] && !resv_pg[p]) run++;
                        else run = 0;
                        if (run == int'(r.page_total)) begin
                            st = p + 1 - run;
                            for (int k = st; k <= p; k++) begin
                                used_pg[k] = 1'b1;
                                if (free_cnt != 0) free_cnt--;
                            end
                            o.alloc_address = 32'(st) << 12;
                            o.ok = 1'b1;
                            break;
                        end
                    end
                end
            end
            pba_pkg::MODE_FREE: begin
                bad = !alloc_ready || r.page_total == 0 || r.release_address[11:0] != 0;
                if (!bad && (64'(r.release_address) + 64'(r.page_total) * 64'd4096
                        > 64'h1_0000_0000)) bad = 1'b1;
                sp = r.release_address >> 12;
                if (!bad && (sp < FIRST_PG || sp + r.page_total > PGS)) bad = 1'b1;
                if (!bad)
                    for (p = 0; p < int'(r.page_total); p++)
                        if (resv_pg[int'(sp) + p]) bad = 1'b1;
                if (!bad) begin
                    for (p = 0; p < int'(r.page_total); p++) begin
                        if (used_pg[int'(sp) + p]) begin
                            used_pg[int'(sp) + p] = 1'b0;
                            if (free_cnt < 17'h1FFFF) free_cnt++;
                        end
                    end
                    o.ok = 1'b1;
                end
            end
            pba_pkg::MODE_SEAL: begin
                if (free_cnt != 0) alloc_ready = 1'b1;
                o.ok = alloc_ready;
            end
            default: ;
        endcase
        o.free_pages = free_cnt;
        o.usable_pages = usable_cnt;
        return o;
    endfunction

    task automatic push_req(logic [2:0] m, logic [63:0] b, logic [63:0] l,
                            logic [16:0] c, logic [31:0] a);
        pba_pkg::t_req r;
        r.mode = m;
        r.range_base = b;
        r.range_length = l;
        r.page_total = c;
        r.release_address = a;
        pending_reqs.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %0s: got %h expected %h at %0t", what, got, want, $realtime);
        n_errors++;
    endtask

    // driver
    always @(posedge i_clk) begin
        req_fire <= req_if.valid && req_if.ready;
        if (req_if.valid && req_if.ready)
            expected_rsps.push_back(predict_page_map(req_if.data));
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (req_if.valid && !req_fire) begin
        end else if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_if.valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
            req_if.data <= pending_reqs.pop_front();
            req_if.valid <= 1'b1;
            req_gap <= pick_gap();
        end else begin
            req_if.valid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (rsp_gap > 0) begin
            rsp_gap <= rsp_gap - 1;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_gap <= pick_gap();
        end
    end

    // monitor
    always @(posedge i_clk) begin
        pba_pkg::t_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(rsp_if.data.ok), 32'hx);
            end else begin
                want = expected_rsps.pop_front();
                n_checked++;
                if (want.ok && want.alloc_address != pba_pkg::NO_ADDR) n_alloc_ok++;
                if (want.ok && rsp_if.data.alloc_address == pba_pkg::NO_ADDR) n_free_ok++;
                if (rsp_if.data.ok !== want.ok)
                    report_mismatch("ok", 32'(rsp_if.data.ok), 32'(want.ok));
                if (rsp_if.data.alloc_address !== want.alloc_address)
                    report_mismatch("alloc_address", rsp_if.data.alloc_address,
                                    want.alloc_address);
                if (rsp_if.data.free_pages !== want.free_pages)
                    report_mismatch("free_pages", 32'(rsp_if.data.free_pages),
                                    32'(want.free_pages));
                if (rsp_if.data.usable_pages !== want.usable_pages)
                    report_mismatch("usable_pages", 32'(rsp_if.data.usable_pages),
                                    32'(want.usable_pages));
            end
        end
    end

    // full-map scans can dominate, so the limit allows every item a worst-case scan
    initial begin
        repeat (500) #20_000_000;
        $display("timeout");
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int r;
        logic [31:0] a;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        for (int p = 0; p < PGS; p++) begin
            used_pg[p] = 1'b1;
            resv_pg[p] = 1'b0;
        end
        usable_cnt = '0;
        free_cnt = '0;
        alloc_ready = 1'b0;

        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'd1, 0);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd1, 32'h0010_0000);
        push_req(pba_pkg::MODE_SEAL, 0, 0, 0, 0);
        push_req(pba_pkg::MODE_AVAIL, 64'h1000, 64'd0, 0, 0);
        push_req(pba_pkg::MODE_AVAIL, 64'h1_0000_0000, 64'h1000, 0, 0);
        push_req(pba_pkg::MODE_AVAIL, 64'h1001, 64'h1000, 0, 0);
        push_req(pba_pkg::MODE_RESERVE, 64'h1000_0000, 64'h5000, 0, 0);
        push_req(pba_pkg::MODE_RESERVE, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
                 0, 0);
        push_req(pba_pkg::MODE_AVAIL, 64'h100, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0);
        push_req(pba_pkg::MODE_RESERVE, 64'h1F_F800, 64'h1000, 0, 0);
        push_req(pba_pkg::MODE_SEAL, 0, 0, 0, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'd0, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'd65537, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'h1FFFF, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'h10000, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'd1, 0);
        push_req(pba_pkg::MODE_ALLOC, 0, 0, 17'd3, 0);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd1, 32'h0010_0800);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd1, 32'h0000_1000);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd2, 32'h0FFF_F000);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'h1FFFF, 32'hFFFF_F000);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd2, 32'h001F_F000);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd0, 32'h0010_0000);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd4, 32'h0030_0000);
        push_req(5, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 17'h1FFFF, 32'hFFFF_FFFF);
        push_req(7, 0, 0, 0, 0);
        push_req(pba_pkg::MODE_FREE, 0, 0, 17'd4, 32'h0010_0000);

        for (int i = 0; i < 1825; i++) begin
            r = $urandom_range(0, 99);
            a = 32'($urandom_range(FIRST_PG, 1280)) << 12;
            if (r < 30) begin
                push_req(pba_pkg::MODE_ALLOC, {$urandom, $urandom}, {$urandom, $urandom},
                         ($urandom_range(0, 199) == 0) ? 17'($urandom)
                                                       : 17'($urandom_range(1, 8)),
                         $urandom);
            end else if (r < 58) begin
                if ($urandom_range(0, 9) == 0) a = $urandom;
                push_req(pba_pkg::MODE_FREE, {$urandom, $urandom}, {$urandom, $urandom},
                         17'($urandom_range(1, 32)), a);
            end else if (r < 78) begin
                push_req(pba_pkg::MODE_AVAIL, 64'(a) + 64'($urandom_range(0, 4095)),
                         64'($urandom_range(1, 65536)), 17'($urandom), $urandom);
            end else if (r < 83) begin
                push_req(pba_pkg::MODE_RESERVE, 64'($urandom_range(0, 32'hFFFF_FFFF)) &
                         64'hFFFF_FFFF, 64'($urandom_range(1, 12000)), 0, 0);
            end else if (r < 90) begin
                push_req(pba_pkg::MODE_SEAL, 0, 0, 0, 0);
            end else begin
                push_req(3'($urandom_range(0, 7)), {$urandom, $urandom},
                         {$urandom, $urandom}, 17'($urandom), $urandom);
            end
        end

        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        wait (pending_reqs.size() == 0 && !req_if.valid);
        wait (expected_rsps.size() == 0);
        repeat (200) @(posedge i_clk);
        $display("checked %0d transactions: %0d allocations and %0d other successes",
                 n_checked, n_alloc_ok, n_free_ok);
        $display("final free %0d of %0d usable pages", free_cnt, usable_cnt);
        if (n_errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
